// ----- hdl/cfv_pkg.sv -----
// ----------------------------------------------------------------------------
// cfv_pkg
// shared types and constants of the checked frame validator
// ----------------------------------------------------------------------------
package cfv_pkg;

  localparam int unsigned HDR_LEN = 24;

  localparam logic [63:0] FNV_BASIS   = 64'hcbf29ce484222325;
  // prime is 2^40 + 2^8 + 0xb3
  localparam logic [7:0]  FNV_PRIME_LO = 8'hb3;

  localparam logic [2:0] ST_VALID   = 3'd0;
  localparam logic [2:0] ST_SIZE    = 3'd1;
  localparam logic [2:0] ST_MAGIC   = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_DIGEST  = 3'd4;

  typedef logic [2:0] status_t;

  // frame state captured on the final byte
  typedef struct packed {
    logic [63:0] pos;
    logic        magic_ok;
    logic [15:0] version;
    logic [63:0] length;
    logic [63:0] digest;
    logic [63:0] hash;
  } frame_sum_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h43;
      2'd1:    b = 8'h48;
      2'd2:    b = 8'h4d;
      default: b = 8'h32;
    endcase
    return b;
  endfunction

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + 64'(x * {56'd0, FNV_PRIME_LO});
  endfunction

endpackage

// ----- hdl/cfv_accum.sv -----
// ----------------------------------------------------------------------------
// cfv_accum
// per-byte header capture, payload hashing and frame summary register
// ----------------------------------------------------------------------------
module cfv_accum
  import cfv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       snap_take,
  output logic       snap_v,
  output frame_sum_t snap
);

  logic [63:0] pos_r, pos_nxt;
  logic        magic_r, magic_nxt;
  logic [15:0] version_r, version_nxt;
  logic [63:0] length_r, length_nxt;
  logic [63:0] digest_r, digest_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic        snap_v_r;
  frame_sum_t  snap_r;
  logic        in_hdr;

  assign in_hdr = (pos_r[63:5] == '0) && (pos_r[4:0] < 5'(HDR_LEN));

  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    length_nxt  = length_r;
    digest_nxt  = digest_r;
    hash_nxt    = hash_r;
    if (in_hdr) begin
      if (pos_r[4:2] == 3'd0) begin
        if (byte_i != magic_byte(pos_r[1:0])) begin
          magic_nxt = 1'b0;
        end
      end else if (pos_r[4:1] == 4'd2) begin
        version_nxt[8*pos_r[0] +: 8] = byte_i;
      end else if (pos_r[4:3] == 2'd1) begin
        length_nxt[8*pos_r[2:0] +: 8] = byte_i;
      end else if (pos_r[4:3] == 2'd2) begin
        digest_nxt[8*pos_r[2:0] +: 8] = byte_i;
      end
    end else begin
      hash_nxt = fnv_step(hash_r, byte_i);
    end
    pos_nxt = (pos_r == '1) ? pos_r : pos_r + 64'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      magic_r   <= 1'b1;
      version_r <= '0;
      length_r  <= '0;
      digest_r  <= '0;
      hash_r    <= FNV_BASIS;
      snap_v_r  <= 1'b0;
    end else begin
      if (go) begin
        if (last_i) begin
          pos_r     <= '0;
          magic_r   <= 1'b1;
          version_r <= '0;
          length_r  <= '0;
          digest_r  <= '0;
          hash_r    <= FNV_BASIS;
        end else begin
          pos_r     <= pos_nxt;
          magic_r   <= magic_nxt;
          version_r <= version_nxt;
          length_r  <= length_nxt;
          digest_r  <= digest_nxt;
          hash_r    <= hash_nxt;
        end
      end
      if (go && last_i) begin
        snap_v_r <= 1'b1;
      end else if (snap_take) begin
        snap_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && last_i) begin
      snap_r.pos      <= pos_nxt;
      snap_r.magic_ok <= magic_nxt;
      snap_r.version  <= version_nxt;
      snap_r.length   <= length_nxt;
      snap_r.digest   <= digest_nxt;
      snap_r.hash     <= hash_nxt;
    end
  end

  assign snap_v = snap_v_r;
  assign snap   = snap_r;

endmodule

// ----- hdl/cfv_check.sv -----
// ----------------------------------------------------------------------------
// cfv_check
// frame status decision and result register
// ----------------------------------------------------------------------------
module cfv_check
  import cfv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         snap_v,
  input  frame_sum_t   snap,
  input  logic [15:0]  exp_version,
  output logic         snap_take,
  input  logic         out_tready,
  output logic         out_tvalid,
  output logic [135:0] out_tdata
);

  logic        out_v_r;
  status_t     status_r, status_nxt;
  logic [63:0] digest_r;
  logic [63:0] count_r, count_nxt;
  logic        short_frame;

  assign short_frame = (snap.pos[63:5] == '0) && (snap.pos[4:0] < 5'(HDR_LEN));
  assign snap_take   = snap_v && (!out_v_r || out_tready);

  always_comb begin
    if (snap.pos == '1) begin
      count_nxt = '1;
    end else if (short_frame) begin
      count_nxt = '0;
    end else begin
      count_nxt = snap.pos - 64'(HDR_LEN);
    end
    if (short_frame) begin
      status_nxt = ST_SIZE;
    end else if (!snap.magic_ok) begin
      status_nxt = ST_MAGIC;
    end else if (snap.version != exp_version) begin
      status_nxt = ST_VERSION;
    end else if (count_nxt != snap.length) begin
      status_nxt = ST_SIZE;
    end else if (snap.hash != snap.digest) begin
      status_nxt = ST_DIGEST;
    end else begin
      status_nxt = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (snap_take) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      status_r <= status_nxt;
      digest_r <= snap.hash;
      count_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, count_r, digest_r, status_r};

endmodule

// ----- hdl/checked_frame_validator.sv -----
// ----------------------------------------------------------------------------
// checked_frame_validator
// byte stream frame checker with 64-bit fnv-1a payload digest
// ----------------------------------------------------------------------------
// the result word of a final byte passes the input, frame summary and result registers
// throughput: one byte per cycle while no final byte is held back, set by the hash update loop
// with two result words held back by out_tready, input stalls at the next final byte
// reset: synchronous active-low rst_n clears frame state, expected version 2
module checked_frame_validator
  import cfv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [2:0] status, [66:3] computed_digest,
                                   // [130:67] payload_count, rest zero
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data    // expected_version
);

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_last_r;
  logic [15:0] exp_version_r;
  logic        go;
  logic        snap_v;
  logic        snap_take;
  frame_sum_t  snap;

  assign go        = in_v_r && (!in_last_r || !snap_v || snap_take);
  assign in_tready = !in_v_r || go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r        <= 1'b0;
      exp_version_r <= 16'd2;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (cfg_valid) begin
        exp_version_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  cfv_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .byte_i    (in_byte_r),
    .last_i    (in_last_r),
    .snap_take (snap_take),
    .snap_v    (snap_v),
    .snap      (snap)
  );

  cfv_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .snap_v      (snap_v),
    .snap        (snap),
    .exp_version (exp_version_r),
    .snap_take   (snap_take),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

endmodule

// ----- hdl/cfv_checker.sv -----
// ----------------------------------------------------------------------------
// cfv_checker
// port-level checks of the checked frame validator
// ----------------------------------------------------------------------------
module cfv_checker
  import cfv_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= ST_DIGEST)
    else $error("status code out of range");

  a_empty_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[130:67] == '0) |-> out_tdata[66:3] == FNV_BASIS)
    else $error("digest differs from basis with no payload");

endmodule

bind checked_frame_validator cfv_checker u_cfv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// random and directed frames through the checked frame validator, with each
// status word checked against an in-bench model of the header and fnv-1a 64
// ----------------------------------------------------------------------------
module tb;
  import cfv_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [63:0] digest;
    logic [63:0] count;
  } frame_result_t;

  typedef enum int {
    FRAME_GOOD, FRAME_BAD_MAGIC, FRAME_BAD_VERSION, FRAME_BAD_LENGTH,
    FRAME_BAD_DIGEST, FRAME_SHORT, FRAME_NOISE
  } frame_kind_t;

  class frame_scoreboard;
    localparam logic [31:0] MAGIC_LE  = 32'h324d4843;
    localparam logic [63:0] HASH_MULT = 64'd1099511628211;

    logic [15:0]     version_cfg;
    logic [63:0]     pos;
    logic            magic_ok;
    logic [15:0]     version_hdr;
    logic [63:0]     length_hdr;
    logic [63:0]     digest_hdr;
    logic [63:0]     hash;
    frame_result_t   status_due[$];
    int              errors;

    function new();
      version_cfg = 16'd2;
      errors = 0;
      clear_frame();
    endfunction

    static function logic [63:0] fnv_next(input logic [63:0] h, input logic [7:0] b);
      return (h ^ {56'd0, b}) * HASH_MULT;
    endfunction

    function void clear_frame();
      pos = '0;
      magic_ok = 1'b1;
      version_hdr = '0;
      length_hdr = '0;
      digest_hdr = '0;
      hash = FNV_BASIS;
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // one accepted input word
    task take_byte(input logic [7:0] b, input logic last);
      frame_result_t r;
      if (pos < 4) begin
        if (b != MAGIC_LE[8*pos[1:0] +: 8]) magic_ok = 1'b0;
      end else if (pos < 6) begin
        version_hdr[8*pos[0] +: 8] = b;
      end else if (pos < 8) begin
      end else if (pos < 16) begin
        length_hdr[8*pos[2:0] +: 8] = b;
      end else if (pos < HDR_LEN) begin
        digest_hdr[8*pos[2:0] +: 8] = b;
      end else begin
        hash = fnv_next(hash, b);
      end
      if (pos != '1) pos++;
      if (last) begin
        if (pos == '1) r.count = '1;
        else if (pos >= HDR_LEN) r.count = pos - HDR_LEN;
        else r.count = '0;
        if (pos < HDR_LEN) r.status = ST_SIZE;
        else if (!magic_ok) r.status = ST_MAGIC;
        else if (version_hdr != version_cfg) r.status = ST_VERSION;
        else if (r.count != length_hdr) r.status = ST_SIZE;
        else if (hash != digest_hdr) r.status = ST_DIGEST;
        else r.status = ST_VALID;
        r.digest = hash;
        status_due = {status_due, r};
        clear_frame();
      end
    endtask

    // one accepted result word
    task check_word(input logic [135:0] w);
      frame_result_t e;
      if (status_due.size() == 0) begin
        report($sformatf("result word with nothing expected: %h", w));
        return;
      end
      e = status_due.pop_front();
      if (w[2:0] !== e.status)
        report($sformatf("status %0d, expected %0d", w[2:0], e.status));
      if (w[66:3] !== e.digest)
        report($sformatf("digest %h, expected %h", w[66:3], e.digest));
      if (w[130:67] !== e.count)
        report($sformatf("payload count %0d, expected %0d", w[130:67], e.count));
      if (w[135:131] !== '0)
        report($sformatf("padding bits %b not zero", w[135:131]));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;    // [7:0] data_byte
  logic         in_tlast = 1'b0;  // last_byte
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;        // [2:0] status, [66:3] digest, [130:67] count
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;    // expected_version

  frame_scoreboard frames = new();
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  checked_frame_validator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) frames.check_word(out_tdata);
  end

  // receiver: random stall bursts and one long hold
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    frames.take_byte(b, last);
  endtask

  task automatic send_frame(input frame_kind_t kind, input int max_payload, output int n);
    logic [7:0]  fr[$];
    logic [7:0]  payload[$];
    logic [63:0] len_field;
    logic [63:0] dig;
    logic [15:0] ver;
    int          plen;
    if (max_payload == 0) plen = 0;
    else if ($urandom_range(0, 9) == 0) plen = $urandom_range(13, max_payload);
    else plen = $urandom_range(0, 12);
    dig = FNV_BASIS;
    for (int i = 0; i < plen; i++) begin
      payload = {payload, 8'($urandom)};
      dig = frame_scoreboard::fnv_next(dig, payload[i]);
    end
    ver = frames.version_cfg;
    len_field = 64'(plen);
    case (kind)
      FRAME_BAD_VERSION: ver ^= 16'($urandom_range(1, 65535));
      FRAME_BAD_LENGTH: begin
        if ($urandom_range(0, 1) == 0) len_field = len_field + 64'd1;
        else len_field ^= {32'($urandom), 31'($urandom), 1'b1};
      end
      FRAME_BAD_DIGEST: dig ^= {32'($urandom), 31'($urandom), 1'b1};
      default: ;
    endcase
    for (int i = 0; i < 4; i++) fr = {fr, frame_scoreboard::MAGIC_LE[8*i +: 8]};
    if (kind == FRAME_BAD_MAGIC) fr[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    fr = {fr, ver[7:0]};
    fr = {fr, ver[15:8]};
    fr = {fr, 8'($urandom)};
    fr = {fr, 8'($urandom)};
    for (int i = 0; i < 8; i++) fr = {fr, len_field[8*i +: 8]};
    for (int i = 0; i < 8; i++) fr = {fr, dig[8*i +: 8]};
    foreach (payload[i]) fr = {fr, payload[i]};
    if (kind == FRAME_SHORT) begin
      plen = $urandom_range(1, HDR_LEN - 1);
      while (fr.size() > plen) void'(fr.pop_back());
    end else if (kind == FRAME_NOISE) begin
      fr.delete();
      repeat ($urandom_range(1, 40)) fr = {fr, 8'($urandom)};
    end
    foreach (fr[i]) send_word(fr[i], i == fr.size() - 1);
    n = fr.size();
  endtask

  task automatic run_frames(input int bytes_goal, input int frames_goal);
    int          bytes_sent;
    int          frames_sent;
    int          n;
    frame_kind_t kind;
    bytes_sent = 0;
    frames_sent = 0;
    while (bytes_sent < bytes_goal || frames_sent < frames_goal) begin
      case ($urandom_range(0, 11))
        6:       kind = FRAME_BAD_MAGIC;
        7:       kind = FRAME_BAD_VERSION;
        8:       kind = FRAME_BAD_LENGTH;
        9:       kind = FRAME_BAD_DIGEST;
        10:      kind = FRAME_SHORT;
        11:      kind = FRAME_NOISE;
        default: kind = FRAME_GOOD;
      endcase
      send_frame(kind, 80, n);
      bytes_sent += n;
      frames_sent++;
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    for (int i = 0; i < 20000 && frames.pending() != 0; i++) @(posedge clk);
    if (frames.pending() != 0)
      frames.report($sformatf("%0d results never arrived", frames.pending()));
    repeat (8) @(posedge clk);
  endtask

  task automatic write_version(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frames.version_cfg = v;
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // short one-byte frame, then a valid frame with empty payload
    send_word(8'hff, 1'b1);
    send_frame(FRAME_GOOD, 0, n);
    drain();

    write_version(16'hffff);
    hold_req = 1'b1;
    run_frames(270, 8);
    drain();

    write_version(16'h0000);
    run_frames(270, 8);
    drain();

    write_version(16'($urandom));
    run_frames(270, 8);
    drain();

    idle_en = 1'b0;
    write_version(16'd2);
    run_frames(270, 8);
    drain();

    if (frames.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
